FILE: hw/rtl/fcp_pkg.sv
// Shared constants, register indexes and controller/datapath interface types
// for the foveated cell position block. No dependencies.
`default_nettype none

package fcp_pkg;

    // Fixed field widths
    localparam int CELL_BITS = 12;
    localparam int GRID_BITS = 5;
    localparam int CFG_IDX_BITS = 2;

    // Largest legal grid side; larger grids give the empty result
    localparam int MAX_GRID = 16;

    // Parameter defaults
    localparam int FRAC_BITS_DEF = 16;
    localparam int SIZE_BITS_DEF = 13;

    // Configuration register indexes
    localparam logic [CFG_IDX_BITS-1:0] REG_FRAME_SIZE = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_FOVEA_SIZE = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_FOVEA_GRID = 2'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_RING_GRID  = 2'd3;

    // Controller -> datapath commands
    typedef struct packed {
        logic load;
        logic set_empty;
        logic fov_setup;
        logic ring_setup;
        logic ring_step;
        logic ring_take;
        logic row_step;
        logic mul;
        logic div_load;
        logic div_step;
        logic out_load;
    } t_cmd;

    // Datapath -> controller status
    typedef struct packed {
        logic bad;
        logic in_fovea;
        logic ring_ok;
        logic row_done;
    } t_sts;

endpackage

`default_nettype wire

FILE: hw/rtl/foveated_cell_position.sv
// An accepted word gives a result for a fovea cell or a ring cell after the row scan, or an
// empty result from a bad setup or from an index past the last ring. The next word is taken
// in the cycle after the result is loaded into the output register.
// Throughput: one cell at a time, set by the 12-step ring-index divider, the row-by-row scan
// and the restoring divider (one quotient bit per cycle, three lanes in parallel).
// Reset: synchronous active-low; clears config registers to 0 and all control state.
`default_nettype none

module foveated_cell_position #(
    parameter int FRAC_BITS = fcp_pkg::FRAC_BITS_DEF,
    parameter int SIZE_BITS = fcp_pkg::SIZE_BITS_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    // Configuration write channel
    input  wire logic                              i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  wire logic [fcp_pkg::CFG_IDX_BITS-1:0]  i_cfg_index,
    input  wire logic [SIZE_BITS-1:0]              i_cfg_data,
    // Cell index input
    input  wire logic                              i_cell_valid,
    output logic                                   o_cell_ready,
    input  wire logic [fcp_pkg::CELL_BITS-1:0]     i_cell_index,
    // Result output
    output logic                                   o_res_valid,
    input  wire logic                              i_res_ready,
    output logic                                   o_valid_res,
    output logic signed [FRAC_BITS+1:0]            o_centre_x,
    output logic signed [FRAC_BITS+1:0]            o_centre_y,
    output logic [FRAC_BITS:0]                     o_pitch
);

    fcp_pkg::t_cmd cmd;
    fcp_pkg::t_sts sts;

    // Config registers take a word every cycle
    assign o_cfg_ready = 1'b1;

    // Sequencer: check config, find ring and row, then divide.
    // The next cell is accepted while a finished result waits in the output register.
    fcp_ctrl #(.FRAC_BITS(FRAC_BITS)) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cell_valid(i_cell_valid),
        .o_cell_ready(o_cell_ready),
        .i_res_ready (i_res_ready),
        .o_res_valid (o_res_valid),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    // Datapath: centre = (W*(2c+1-G) + G*F) * 2^FRAC_BITS / (2*G*F),
    // pitch = 2W * 2^FRAC_BITS / (2*G*F), both rounded half away from zero
    fcp_dp #(.FRAC_BITS(FRAC_BITS), .SIZE_BITS(SIZE_BITS)) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_cell_index(i_cell_index),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_valid_res (o_valid_res),
        .o_centre_x  (o_centre_x),
        .o_centre_y  (o_centre_y),
        .o_pitch     (o_pitch)
    );

`ifndef SYNTHESIS
    // Busy right after taking a word
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cell_valid && o_cell_ready) |=> !o_cell_ready)
        else $error("accepted a second word without finishing the first");

    // An empty result carries zero fields
    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && !o_valid_res) |->
            (o_centre_x == '0) && (o_centre_y == '0) && (o_pitch == '0))
        else $error("empty result with nonzero fields");

    // No result can appear while the block sits idle
    a_no_result_from_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cell_ready && o_res_valid && i_res_ready) |=> !o_res_valid)
        else $error("result appeared without a word in flight");

    // Reset leaves the block idle and empty
    a_reset_state: assert property (@(posedge i_clk)
        !i_rst_n |=> (o_cell_ready && !o_res_valid))
        else $error("block not idle after reset");
`endif

endmodule

`default_nettype wire

FILE: hw/rtl/fcp_div_lane.sv
// One lane of the restoring divider: rounded, saturated quotient, one bit per cycle while i_step is high.
// Uses fcp_pkg for field widths.
`default_nettype none

module fcp_div_lane #(
    parameter int FRAC_BITS = fcp_pkg::FRAC_BITS_DEF,
    parameter int SIZE_BITS = fcp_pkg::SIZE_BITS_DEF
) (
    input  wire logic                                          i_clk,
    input  wire logic                                          i_load,
    input  wire logic                                          i_step,
    input  wire logic [SIZE_BITS+fcp_pkg::GRID_BITS+FRAC_BITS+2:0] i_num,
    input  wire logic                                          i_neg,
    input  wire logic [SIZE_BITS+fcp_pkg::GRID_BITS:0]         i_den,
    output logic signed [FRAC_BITS+1:0]                        o_value
);

    localparam int QW = FRAC_BITS + 2;
    localparam int DB = SIZE_BITS + fcp_pkg::GRID_BITS + 1;
    localparam int NB = DB + QW;
    localparam logic [QW-1:0] LIM = QW'(1) << (FRAC_BITS + 1);

    logic [DB-1:0] r_rem;
    logic [QW-1:0] r_low;
    logic          r_ovf;
    logic          r_neg;

    logic [DB-1:0] hi_part;
    logic [DB:0]   sh;
    logic [DB:0]   sub;
    logic          ge;
    logic          sat_pos;
    logic          sat_neg;
    logic [QW-1:0] neg_mag;

    assign hi_part = i_num[NB-1:QW];
    assign sh      = {r_rem, r_low[QW-1]};
    assign sub     = sh - {1'b0, i_den};
    assign ge      = sh >= {1'b0, i_den};

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_rem <= hi_part;
            r_low <= i_num[QW-1:0];
            r_ovf <= hi_part >= i_den;  // quotient would not fit QW bits
            r_neg <= i_neg;
        end else if (i_step) begin
            r_rem <= ge ? sub[DB-1:0] : sh[DB-1:0];
            r_low <= {r_low[QW-2:0], ge};
        end
    end

    assign sat_pos = r_ovf || (r_low >= LIM);
    assign sat_neg = r_ovf || (r_low > LIM);
    assign neg_mag = sat_neg ? LIM : r_low;

    always_comb begin
        if (r_neg) begin
            o_value = $signed(QW'(0) - neg_mag);
        end else begin
            o_value = $signed(sat_pos ? (LIM - QW'(1)) : r_low);
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/fcp_dp.sv
// Datapath: config registers, ring divider, row scan, products and divider lanes.
// Uses fcp_pkg; instantiates fcp_div_lane.
`default_nettype none

module fcp_dp #(
    parameter int FRAC_BITS = fcp_pkg::FRAC_BITS_DEF,
    parameter int SIZE_BITS = fcp_pkg::SIZE_BITS_DEF
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_cfg_valid,
    input  wire logic [fcp_pkg::CFG_IDX_BITS-1:0]      i_cfg_index,
    input  wire logic [SIZE_BITS-1:0]                  i_cfg_data,
    input  wire logic [fcp_pkg::CELL_BITS-1:0]         i_cell_index,
    input  wire fcp_pkg::t_cmd                         i_cmd,
    output fcp_pkg::t_sts                              o_sts,
    output logic                                       o_valid_res,
    output logic signed [FRAC_BITS+1:0]                o_centre_x,
    output logic signed [FRAC_BITS+1:0]                o_centre_y,
    output logic [FRAC_BITS:0]                         o_pitch
);

    localparam int SB  = SIZE_BITS;
    localparam int GB  = fcp_pkg::GRID_BITS;
    localparam int CB  = fcp_pkg::CELL_BITS;
    localparam int SQB = 2 * GB;
    localparam int WB  = SB + 1;
    localparam int KB  = GB + 2;
    localparam int PB  = WB + 1 + KB;
    localparam int GFB = GB + SB;
    localparam int MB  = SB + GB + 2;
    localparam int TB  = MB + 1;
    localparam int DB  = GFB + 1;
    localparam int NB  = MB + FRAC_BITS + 1;
    localparam int SHB = 2 * SB;

    // Configuration registers
    logic [SB-1:0] r_frame;
    logic [SB-1:0] r_fovea;
    logic [GB-1:0] r_fgrid;
    logic [GB-1:0] r_rgrid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame <= '0;
            r_fovea <= '0;
            r_fgrid <= '0;
            r_rgrid <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                fcp_pkg::REG_FRAME_SIZE: r_frame <= i_cfg_data;
                fcp_pkg::REG_FOVEA_SIZE: r_fovea <= i_cfg_data;
                fcp_pkg::REG_FOVEA_GRID: r_fgrid <= i_cfg_data[GB-1:0];
                fcp_pkg::REG_RING_GRID:  r_rgrid <= i_cfg_data[GB-1:0];
            endcase
        end
    end

    // Grid geometry
    logic [SQB-1:0] fsq, rsq, hsq, ring_span;
    logic [GB-1:0]  hole, lo, hi;

    assign fsq       = SQB'(r_fgrid) * SQB'(r_fgrid);
    assign rsq       = SQB'(r_rgrid) * SQB'(r_rgrid);
    assign hole      = r_rgrid >> 1;
    assign lo        = (r_rgrid - hole) >> 1;
    assign hi        = lo + hole;
    assign hsq       = SQB'(hole) * SQB'(hole);
    assign ring_span = rsq - hsq;

    // Per-item registers
    logic [CB-1:0]  r_cell;
    logic           r_empty;
    logic [CB-1:0]  r_rq;     // ring dividend, then quotient
    logic [SQB-1:0] r_rrem;
    logic [SQB-1:0] r_rest;
    logic [GB-1:0]  r_row;
    logic [GB-1:0]  r_g;
    logic [WB-1:0]  r_w;
    logic           r_hole_on;
    logic signed [PB-1:0] r_wkx, r_wky;
    logic [GFB-1:0] r_gf;

    // Ring index divider step
    logic [SQB:0] rd_sh, rd_sub;
    logic         rd_ge;

    assign rd_sh  = {r_rrem, r_rq[CB-1]};
    assign rd_sub = rd_sh - {1'b0, ring_span};
    assign rd_ge  = rd_sh >= {1'b0, ring_span};

    // Ring exists when fovea << (ring-1) stays below the frame
    logic [SHB-1:0] shifted;
    logic           ring_ok;

    assign shifted = SHB'(r_fovea) << r_rq;
    assign ring_ok = (r_fovea != '0) && (r_rq < CB'(SB)) && (shifted < SHB'(r_frame));

    // Row scan, hole rows are shorter
    logic          row_in_hole;
    logic [GB-1:0] row_len;
    logic          row_done;
    logic [GB-1:0] col;

    assign row_in_hole = r_hole_on && (r_row >= lo) && (r_row < hi);
    assign row_len     = row_in_hole ? (r_rgrid - hole) : r_g;
    assign row_done    = r_rest < SQB'(row_len);
    assign col = (row_in_hole && (r_rest[GB-1:0] >= lo)) ? (r_rest[GB-1:0] + hole)
                                                          : r_rest[GB-1:0];

    // Offsets 2c+1-G and products
    logic signed [KB-1:0] kx, ky;
    logic signed [WB:0]   ws;
    logic signed [PB-1:0] wkx, wky;

    assign kx  = $signed({1'b0, col, 1'b1}) - $signed({2'b00, r_g});
    assign ky  = $signed({1'b0, r_row, 1'b1}) - $signed({2'b00, r_g});
    assign ws  = $signed({1'b0, r_w});
    assign wkx = ws * kx;
    assign wky = ws * ky;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cell <= i_cell_index;
        end
        if (i_cmd.ring_setup) begin
            r_rq   <= r_cell - CB'(fsq);
            r_rrem <= '0;
        end else if (i_cmd.ring_step) begin
            r_rrem <= rd_ge ? rd_sub[SQB-1:0] : rd_sh[SQB-1:0];
            r_rq   <= {r_rq[CB-2:0], rd_ge};
        end
        if (i_cmd.fov_setup) begin
            r_rest    <= r_cell[SQB-1:0];
            r_row     <= '0;
            r_g       <= r_fgrid;
            r_w       <= {1'b0, r_fovea};
            r_hole_on <= 1'b0;
        end else if (i_cmd.ring_take) begin
            r_rest    <= r_rrem;
            r_row     <= '0;
            r_g       <= r_rgrid;
            r_w       <= {shifted[SB-1:0], 1'b0};
            r_hole_on <= 1'b1;
        end else if (i_cmd.row_step) begin
            r_rest <= r_rest - SQB'(row_len);
            r_row  <= r_row + GB'(1);
        end
        if (i_cmd.mul) begin
            r_wkx <= wkx;
            r_wky <= wky;
            r_gf  <= GFB'(r_g) * GFB'(r_frame);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_empty <= 1'b0;
        end else if (i_cmd.load) begin
            r_empty <= 1'b0;
        end else if (i_cmd.set_empty) begin
            r_empty <= 1'b1;
        end
    end

    // Numerators: (|t| << FRAC_BITS) + G*F, denominator 2*G*F
    logic signed [TB-1:0] tx, ty, ntx, nty;
    logic [MB-1:0]        magx, magy, magp;
    logic [NB-1:0]        numx, numy, nump;
    logic [DB-1:0]        den;

    assign tx   = TB'(r_wkx) + TB'($signed({1'b0, r_gf}));
    assign ty   = TB'(r_wky) + TB'($signed({1'b0, r_gf}));
    assign ntx  = -tx;
    assign nty  = -ty;
    assign magx = tx[TB-1] ? ntx[MB-1:0] : tx[MB-1:0];
    assign magy = ty[TB-1] ? nty[MB-1:0] : ty[MB-1:0];
    assign magp = MB'({r_w, 1'b0});
    assign numx = (NB'(magx) << FRAC_BITS) + NB'(r_gf);
    assign numy = (NB'(magy) << FRAC_BITS) + NB'(r_gf);
    assign nump = (NB'(magp) << FRAC_BITS) + NB'(r_gf);
    assign den  = {r_gf, 1'b0};

    logic signed [FRAC_BITS+1:0] val_x, val_y, val_p;

    fcp_div_lane #(.FRAC_BITS(FRAC_BITS), .SIZE_BITS(SIZE_BITS)) u_lane_x (
        .i_clk  (i_clk),
        .i_load (i_cmd.div_load),
        .i_step (i_cmd.div_step),
        .i_num  (numx),
        .i_neg  (tx[TB-1]),
        .i_den  (den),
        .o_value(val_x)
    );

    fcp_div_lane #(.FRAC_BITS(FRAC_BITS), .SIZE_BITS(SIZE_BITS)) u_lane_y (
        .i_clk  (i_clk),
        .i_load (i_cmd.div_load),
        .i_step (i_cmd.div_step),
        .i_num  (numy),
        .i_neg  (ty[TB-1]),
        .i_den  (den),
        .o_value(val_y)
    );

    fcp_div_lane #(.FRAC_BITS(FRAC_BITS), .SIZE_BITS(SIZE_BITS)) u_lane_p (
        .i_clk  (i_clk),
        .i_load (i_cmd.div_load),
        .i_step (i_cmd.div_step),
        .i_num  (nump),
        .i_neg  (1'b0),
        .i_den  (den),
        .o_value(val_p)
    );

    // Output word register
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_valid_res <= !r_empty;
            o_centre_x  <= r_empty ? '0 : val_x;
            o_centre_y  <= r_empty ? '0 : val_y;
            o_pitch     <= r_empty ? '0 : val_p[FRAC_BITS:0];
        end
    end

    assign o_sts.bad      = (r_frame == '0) || (r_fgrid == '0) || (r_rgrid == '0)
                            || (int'(r_fgrid) > fcp_pkg::MAX_GRID)
                            || (int'(r_rgrid) > fcp_pkg::MAX_GRID);
    assign o_sts.in_fovea = r_cell < CB'(fsq);
    assign o_sts.ring_ok  = ring_ok;
    assign o_sts.row_done = row_done;

endmodule

`default_nettype wire

FILE: hw/rtl/fcp_ctrl.sv
// Controller state machine: sequences checks, ring division, row scan and divide.
// Uses fcp_pkg command/status types.
`default_nettype none

module fcp_ctrl #(
    parameter int FRAC_BITS = fcp_pkg::FRAC_BITS_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_cell_valid,
    output logic               o_cell_ready,
    input  wire logic          i_res_ready,
    output logic               o_res_valid,
    input  wire fcp_pkg::t_sts i_sts,
    output fcp_pkg::t_cmd      o_cmd
);

    localparam int QW    = FRAC_BITS + 2;
    localparam int STEPS = (QW > fcp_pkg::CELL_BITS) ? QW : fcp_pkg::CELL_BITS;
    localparam int CW    = $clog2(STEPS);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_CHECK = 4'd1;
    localparam logic [3:0] S_RDIV  = 4'd2;
    localparam logic [3:0] S_RCHK  = 4'd3;
    localparam logic [3:0] S_ROW   = 4'd4;
    localparam logic [3:0] S_PREP  = 4'd5;
    localparam logic [3:0] S_DIV   = 4'd6;
    localparam logic [3:0] S_DONE  = 4'd7;

    logic [3:0]    r_state, n_state;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          r_res_valid, n_res_valid;

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_cell_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_CHECK;
                end
            end
            S_CHECK: begin
                priority if (i_sts.bad) begin
                    o_cmd.set_empty = 1'b1;
                    n_state         = S_DONE;
                end else if (i_sts.in_fovea) begin
                    o_cmd.fov_setup = 1'b1;
                    n_state         = S_ROW;
                end else begin
                    o_cmd.ring_setup = 1'b1;
                    n_cnt            = CW'(fcp_pkg::CELL_BITS - 1);
                    n_state          = S_RDIV;
                end
            end
            S_RDIV: begin
                o_cmd.ring_step = 1'b1;
                if (r_cnt == '0) begin
                    n_state = S_RCHK;
                end else begin
                    n_cnt = r_cnt - CW'(1);
                end
            end
            S_RCHK: begin
                if (i_sts.ring_ok) begin
                    o_cmd.ring_take = 1'b1;
                    n_state         = S_ROW;
                end else begin
                    o_cmd.set_empty = 1'b1;
                    n_state         = S_DONE;
                end
            end
            S_ROW: begin
                if (i_sts.row_done) begin
                    o_cmd.mul = 1'b1;
                    n_state   = S_PREP;
                end else begin
                    o_cmd.row_step = 1'b1;
                end
            end
            S_PREP: begin
                o_cmd.div_load = 1'b1;
                n_cnt          = CW'(QW - 1);
                n_state        = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (r_cnt == '0) begin
                    n_state = S_DONE;
                end else begin
                    n_cnt = r_cnt - CW'(1);
                end
            end
            S_DONE: begin
                if (!r_res_valid || i_res_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        if (o_cmd.out_load) begin
            n_res_valid = 1'b1;
        end else if (i_res_ready) begin
            n_res_valid = 1'b0;
        end else begin
            n_res_valid = r_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_res_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_res_valid <= n_res_valid;
        end
    end

    assign o_cell_ready = (r_state == S_IDLE);
    assign o_res_valid  = r_res_valid;

endmodule

`default_nettype wire
